// File: rtl/core/sitlu_pkg.sv
// ----------------------------------------------------------------------------
// sitlu_pkg
// Shared types and constants for the sorted identifier table lookup unit.
// ----------------------------------------------------------------------------
package sitlu_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned SLOT_W    = 8;
    localparam int unsigned COUNT_W   = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT = 2'd0,
        CFG_IMAGE_BASE  = 2'd1,
        CFG_BASE_SIZE   = 2'd2,
        CFG_ROLL_SIZE   = 2'd3
    } t_cfg_idx;

    // Item operation codes.
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // One table slot as it sits in the table memory.
    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] roll_ofs;
        logic [DATA_W-1:0] sel_ofs;
    } t_entry;

    // Image layout registers used to build the result addresses.
    typedef struct packed {
        logic [DATA_W-1:0] image_base;
        logic [DATA_W-1:0] base_size;
        logic [DATA_W-1:0] roll_size;
    } t_img_cfg;

endpackage

// File: rtl/core/sorted_id_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// sorted_id_table_lookup_unit
// Sorted identifier table with binary-search lookup of image addresses.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a clock edge where start is high and busy is
// low. A load item (i_op = load) writes identifier and both offsets into
// slot i_slot and gives no result; busy stays low, so loads can be issued
// every cycle. Slots at or above TABLE_DEPTH are dropped.
// A lookup item binary-searches the first entry_count slots. Each halving
// step is one table memory read followed by one compare. A lookup that
// hits shows its result after the compare of that step, and one that
// misses shows it after the read state finds the range empty. busy is
// high for the whole search; the next item can be taken in the result cycle.
// The result is shown for exactly one cycle with o_valid high; the receiver
// cannot stall it. A miss returns all-zero payload.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at
// once and must be made while busy is low. Reset clears the configuration
// registers and the sequencer state; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_id_table_lookup_unit #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_op,
    input  logic [sitlu_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [sitlu_pkg::DATA_W-1:0]  i_hotspot_id,
    input  logic [sitlu_pkg::DATA_W-1:0]         i_rollover_offset,
    input  logic [sitlu_pkg::DATA_W-1:0]         i_selection_offset,
    input  logic                                 i_cfg_we,
    input  logic [sitlu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sitlu_pkg::DATA_W-1:0]         i_cfg_wdata,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [sitlu_pkg::SLOT_W-1:0]         o_found_slot,
    output logic [sitlu_pkg::DATA_W-1:0]         o_rollover_addr,
    output logic [sitlu_pkg::DATA_W-1:0]         o_selection_addr
);
    import sitlu_pkg::*;

    localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = AW + 1;

    logic [COUNT_W-1:0] r_entry_count;
    t_img_cfg           r_img;

    logic               w_accept;
    logic               w_load;
    logic               w_lookup;
    logic [CNT_W-1:0]   w_count;
    logic [AW-1:0]      w_raddr;
    t_entry             w_wentry;
    t_entry             w_rentry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_img         <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENTRY_COUNT: r_entry_count    <= i_cfg_wdata[COUNT_W-1:0];
                CFG_IMAGE_BASE:  r_img.image_base <= i_cfg_wdata;
                CFG_BASE_SIZE:   r_img.base_size  <= i_cfg_wdata;
                CFG_ROLL_SIZE:   r_img.roll_size  <= i_cfg_wdata;
                default:         r_img            <= r_img;
            endcase
        end
    end

    assign w_accept = start && !busy;
    assign w_load   = w_accept && (t_op'(i_op) == OP_LOAD)
                      && (32'(i_slot) < 32'(TABLE_DEPTH));
    assign w_lookup = w_accept && (t_op'(i_op) == OP_LOOKUP);

    // A count beyond the table depth searches the whole table.
    assign w_count = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(r_entry_count);

    assign w_wentry.id       = i_hotspot_id;
    assign w_wentry.roll_ofs = i_rollover_offset;
    assign w_wentry.sel_ofs  = i_selection_offset;

    sitlu_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(i_slot)),
        .i_wdata (w_wentry),
        .i_raddr (w_raddr),
        .o_rdata (w_rentry)
    );

    sitlu_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_lookup),
        .i_key            (i_hotspot_id),
        .i_count          (w_count),
        .i_img            (r_img),
        .o_busy           (busy),
        .o_raddr          (w_raddr),
        .i_rdata          (w_rentry),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_found_slot     (o_found_slot),
        .o_rollover_addr  (o_rollover_addr),
        .o_selection_addr (o_selection_addr)
    );

endmodule

// File: rtl/core/sitlu_ram.sv
// ----------------------------------------------------------------------------
// sitlu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sitlu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sitlu_search.sv
// ----------------------------------------------------------------------------
// sitlu_search
// Binary search sequencer over the table memory. Each halving step issues
// one read and compares the returned identifier in the following cycle.
// ----------------------------------------------------------------------------
module sitlu_search #(
    parameter int unsigned TABLE_DEPTH = 256,
    localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int unsigned CNT_W = AW + 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [sitlu_pkg::DATA_W-1:0]  i_key,
    input  logic [CNT_W-1:0]                     i_count,
    input  sitlu_pkg::t_img_cfg                  i_img,
    output logic                                 o_busy,
    output logic [AW-1:0]                        o_raddr,
    input  sitlu_pkg::t_entry                    i_rdata,
    output logic                                 o_valid,
    output logic                                 o_found,
    output logic [sitlu_pkg::SLOT_W-1:0]         o_found_slot,
    output logic [sitlu_pkg::DATA_W-1:0]         o_rollover_addr,
    output logic [sitlu_pkg::DATA_W-1:0]         o_selection_addr
);
    import sitlu_pkg::*;

    // Bounds carry one bit beyond the count plus a sign, so high can reach -1.
    localparam int unsigned SW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CMP  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_valid, n_valid;
    logic signed [SW-1:0]     r_low, n_low;
    logic signed [SW-1:0]     r_high, n_high;
    logic [AW-1:0]            r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0]        r_roll_base, n_roll_base;
    logic [DATA_W-1:0]        r_sel_base, n_sel_base;
    logic                     r_found, n_found;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [DATA_W-1:0]        r_roll_addr, n_roll_addr;
    logic [DATA_W-1:0]        r_sel_addr, n_sel_addr;

    logic signed [SW-1:0]     w_span;
    logic signed [SW-1:0]     w_mid;
    logic signed [SW-1:0]     w_mid_reg;
    logic signed [DATA_W-1:0] w_id;
    logic                     w_empty;

    assign w_span    = r_high - r_low;
    assign w_mid     = r_low + (w_span >>> 1);
    assign w_mid_reg = $signed({2'b00, r_mid});
    assign w_empty   = (r_low > r_high);
    assign w_id      = $signed(i_rdata.id);

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_low       = r_low;
        n_high      = r_high;
        n_mid       = r_mid;
        n_key       = r_key;
        n_roll_base = r_roll_base;
        n_sel_base  = r_sel_base;
        n_found     = r_found;
        n_slot      = r_slot;
        n_roll_addr = r_roll_addr;
        n_sel_addr  = r_sel_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_low       = '0;
                    n_high      = $signed({1'b0, i_count}) - SW'(1);
                    n_key       = i_key;
                    n_roll_base = i_img.image_base + i_img.base_size;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                n_sel_base = r_roll_base + i_img.roll_size;
                if (w_empty) begin
                    n_valid     = 1'b1;
                    n_found     = 1'b0;
                    n_slot      = '0;
                    n_roll_addr = '0;
                    n_sel_addr  = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_mid   = w_mid[AW-1:0];
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_id > r_key) begin
                    n_high  = w_mid_reg - SW'(1);
                    n_state = S_READ;
                end else if (w_id < r_key) begin
                    n_low   = w_mid_reg + SW'(1);
                    n_state = S_READ;
                end else begin
                    n_valid     = 1'b1;
                    n_found     = 1'b1;
                    n_slot      = SLOT_W'(r_mid);
                    n_roll_addr = r_roll_base + i_rdata.roll_ofs;
                    n_sel_addr  = r_sel_base + i_rdata.sel_ofs;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low       <= n_low;
        r_high      <= n_high;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_roll_base <= n_roll_base;
        r_sel_base  <= n_sel_base;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_roll_addr <= n_roll_addr;
        r_sel_addr  <= n_sel_addr;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_raddr          = w_mid[AW-1:0];
    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_found_slot     = r_slot;
    assign o_rollover_addr  = r_roll_addr;
    assign o_selection_addr = r_sel_addr;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
            (o_found_slot == '0 && o_rollover_addr == '0 && o_selection_addr == '0))
        else $error("miss result carries nonzero payload");

    a_cmp_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_low <= r_high))
        else $error("compare step entered with an empty range");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("lookup accepted but search did not start");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result issued while search still running");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted identifier table lookup unit.
// ----------------------------------------------------------------------------
// Table loads and lookups are queued by a stimulus process and driven one
// item per handshake with random gaps. A monitor keeps a shadow copy of the
// table and the image layout registers and predicts every lookup answer at
// acceptance. It then compares each strobed result, field by field, with the
// oldest prediction. The run steps through several table sizes and layouts:
// empty, tiny, full, oversized, sorted, repeated and scrambled identifiers.
// ----------------------------------------------------------------------------
module tb;

    import sitlu_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 30;

    typedef enum int {
        ORDER_STRICT,
        ORDER_REPEATS,
        ORDER_SCRAMBLED
    } t_order;

    typedef struct {
        t_op                       op;
        logic [SLOT_W-1:0]         slot;
        logic signed [DATA_W-1:0]  id;
        logic [DATA_W-1:0]         roll_ofs;
        logic [DATA_W-1:0]         sel_ofs;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  roll_addr;
        logic [DATA_W-1:0]  sel_addr;
    } t_answer;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       i_op = 1'b0;
    logic [SLOT_W-1:0]          i_slot = '0;
    logic signed [DATA_W-1:0]   i_hotspot_id = '0;
    logic [DATA_W-1:0]          i_rollover_offset = '0;
    logic [DATA_W-1:0]          i_selection_offset = '0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [DATA_W-1:0]          i_cfg_wdata = '0;
    logic                       o_valid;
    logic                       o_found;
    logic [SLOT_W-1:0]          o_found_slot;
    logic [DATA_W-1:0]          o_rollover_addr;
    logic [DATA_W-1:0]          o_selection_addr;

    // Shadow of the block: table contents and layout registers.
    logic signed [DATA_W-1:0]   id_tbl   [TABLE_DEPTH];
    logic [DATA_W-1:0]          roll_tbl [TABLE_DEPTH];
    logic [DATA_W-1:0]          sel_tbl  [TABLE_DEPTH];
    logic [COUNT_W-1:0]         cfg_count = '0;
    logic [DATA_W-1:0]          cfg_base  = '0;
    logic [DATA_W-1:0]          cfg_bsize = '0;
    logic [DATA_W-1:0]          cfg_rsize = '0;

    // Identifiers as the stimulus loaded them, used to aim lookups at hits.
    logic signed [DATA_W-1:0]   stim_ids [TABLE_DEPTH];

    t_item      items_to_send[$];
    t_answer    answers_due[$];
    int         send_gap = 0;
    bit         calm = 1'b0;
    int         errors = 0;
    int         loads_taken = 0;
    int         lookups_taken = 0;
    int         hits_seen = 0;
    int         layouts = 0;
    int         quiet = 0;

    sorted_id_table_lookup_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_slot             (i_slot),
        .i_hotspot_id       (i_hotspot_id),
        .i_rollover_offset  (i_rollover_offset),
        .i_selection_offset (i_selection_offset),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_found            (o_found),
        .o_found_slot       (o_found_slot),
        .o_rollover_addr    (o_rollover_addr),
        .o_selection_addr   (o_selection_addr)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            id_tbl[s]   = '0;
            roll_tbl[s] = '0;
            sel_tbl[s]  = '0;
            stim_ids[s] = '0;
        end
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Binary search over the shadow table, same halving steps as the block.
    function automatic t_answer search_table(logic signed [DATA_W-1:0] key);
        t_answer            ans;
        int                 lo;
        int                 hi;
        int                 mid;
        int                 span;
        logic signed [DATA_W-1:0] v;
        ans  = '0;
        span = (int'(cfg_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_count);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi && !ans.found) begin
            mid = lo + (hi - lo) / 2;
            v   = id_tbl[mid];
            if (v > key) begin
                hi = mid - 1;
            end else if (v < key) begin
                lo = mid + 1;
            end else begin
                ans.found     = 1'b1;
                ans.slot      = mid[SLOT_W-1:0];
                ans.roll_addr = cfg_base + cfg_bsize + roll_tbl[mid];
                ans.sel_addr  = cfg_base + cfg_bsize + cfg_rsize + sel_tbl[mid];
            end
        end
        return ans;
    endfunction

    task automatic send_next();
        t_item it;
        it = items_to_send.pop_front();
        start              <= 1'b1;
        i_op               <= it.op;
        i_slot             <= it.slot;
        i_hotspot_id       <= it.id;
        i_rollover_offset  <= it.roll_ofs;
        i_selection_offset <= it.sel_ofs;
    endtask

    // Driver: holds an item until it is taken, then waits a drawn gap.
    always @(posedge i_clk) begin : driver_blk
        int g;
        if (!i_rst_n) begin
            start    <= 1'b0;
            send_gap <= 0;
        end else if (start && !busy) begin
            g = calm ? 0 : $urandom_range(0, 12);
            if (g == 0 && items_to_send.size() != 0) begin
                send_next();
            end else begin
                start    <= 1'b0;
                send_gap <= g;
            end
        end else if (!start) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
            end else if (items_to_send.size() != 0) begin
                send_next();
            end
        end
    end

    // Monitor: checks strobed results, then updates the shadow on accepted items.
    always @(posedge i_clk) begin : monitor_blk
        t_answer want;
        if (!i_rst_n) begin
            quiet <= 0;
        end else begin
            if (o_valid === 1'b1) begin
                if (o_found === 1'b1) begin
                    hits_seen++;
                end
                if (answers_due.size() == 0) begin
                    note_error("result strobed with no lookup outstanding");
                end else begin
                    want = answers_due.pop_front();
                    if (o_found !== want.found) begin
                        note_error($sformatf("found: got %b, want %b", o_found, want.found));
                    end
                    if (o_found_slot !== want.slot) begin
                        note_error($sformatf("found_slot: got %0d, want %0d",
                                             o_found_slot, want.slot));
                    end
                    if (o_rollover_addr !== want.roll_addr) begin
                        note_error($sformatf("rollover_addr: got %h, want %h",
                                             o_rollover_addr, want.roll_addr));
                    end
                    if (o_selection_addr !== want.sel_addr) begin
                        note_error($sformatf("selection_addr: got %h, want %h",
                                             o_selection_addr, want.sel_addr));
                    end
                end
            end
            if (start && !busy) begin
                if (i_op == OP_LOAD) begin
                    id_tbl[i_slot]   = i_hotspot_id;
                    roll_tbl[i_slot] = i_rollover_offset;
                    sel_tbl[i_slot]  = i_selection_offset;
                    loads_taken++;
                end else begin
                    answers_due.push_back(search_table(i_hotspot_id));
                    lookups_taken++;
                end
            end
            if ((start && !busy) || o_valid === 1'b1 || i_cfg_we) begin
                quiet <= 0;
            end else if (quiet + 1 >= QUIET_LIMIT) begin
                $display("Stalled for %0d cycles with %0d results outstanding",
                         QUIET_LIMIT, answers_due.size());
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic queue_load(input int slot, input logic signed [DATA_W-1:0] id,
                              input logic [DATA_W-1:0] ro, input logic [DATA_W-1:0] so);
        t_item it;
        it.op       = OP_LOAD;
        it.slot     = slot[SLOT_W-1:0];
        it.id       = id;
        it.roll_ofs = ro;
        it.sel_ofs  = so;
        stim_ids[slot[SLOT_W-1:0]] = id;
        items_to_send.push_back(it);
    endtask

    // The slot and offset fields are ignored on a lookup, so they carry noise.
    task automatic queue_lookup(input logic signed [DATA_W-1:0] key);
        t_item it;
        it.op       = OP_LOOKUP;
        it.slot     = SLOT_W'($urandom);
        it.id       = key;
        it.roll_ofs = $urandom;
        it.sel_ofs  = $urandom;
        items_to_send.push_back(it);
    endtask

    task automatic fill_table(input int n, input t_order order);
        longint spread;
        longint acc;
        spread = longint'(n) * (64'd1 << 23);
        acc    = -64'sd2147483648 + (longint'($urandom) % (64'd4294967296 - spread));
        for (int s = 0; s < n; s++) begin
            case (order)
                ORDER_STRICT:  acc += $urandom_range(1, 1 << 23);
                ORDER_REPEATS: acc += $urandom_range(0, 2);
                default:       acc = longint'($signed($urandom));
            endcase
            queue_load(s, acc[DATA_W-1:0], $urandom, $urandom);
        end
    endtask

    // Mostly keys that sit in the table or right next to one, some random
    // keys, and an occasional stray load that may break the ordering.
    task automatic queue_lookups(input int n, input int span);
        logic signed [DATA_W-1:0] key;
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            key  = $urandom;
            if (span > 0 && kind <= 7) begin
                key = stim_ids[$urandom_range(0, span - 1)];
            end
            if (span > 0 && kind == 6) begin
                key = key + 1;
            end
            if (span > 0 && kind == 7) begin
                key = key - 1;
            end
            if (kind == 9) begin
                queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom, $urandom);
            end
            queue_lookup(key);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_ENTRY_COUNT: cfg_count = val[COUNT_W-1:0];
            CFG_IMAGE_BASE:  cfg_base  = val;
            CFG_BASE_SIZE:   cfg_bsize = val;
            default:         cfg_rsize = val;
        endcase
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_layout(input logic [DATA_W-1:0] count, input logic [DATA_W-1:0] base,
                              input logic [DATA_W-1:0] bsize, input logic [DATA_W-1:0] rsize);
        write_reg(CFG_ENTRY_COUNT, count);
        write_reg(CFG_IMAGE_BASE, base);
        write_reg(CFG_BASE_SIZE, bsize);
        write_reg(CFG_ROLL_SIZE, rsize);
        layouts++;
        calm = ($urandom_range(0, 3) == 0);
        @(negedge i_clk);
    endtask

    // Waits until everything queued is taken and answered, then lets a full
    // search time pass so that no load or lookup is still in flight.
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (items_to_send.size() != 0 || start || answers_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int n_slots;
        t_order order;
        do begin
            @(negedge i_clk);
        end while (i_rst_n !== 1'b1);

        // Reset layout has an empty table: every lookup misses.
        queue_lookup(32'sd0);
        queue_lookup(32'sh80000000);
        queue_load(0, 32'sh80000000, '0, '0);
        queue_load(1, -32'sd1, '1, '1);
        queue_load(2, 32'sd0, 32'h12345678, 32'hA5A5A5A5);
        queue_load(3, 32'sh7FFFFFFF, '1, '0);
        queue_load(255, 32'sh5A5A5A5A, '1, '1);
        settle();

        // All layout sizes at their top value, so both address sums wrap.
        set_layout(4, '1, '1, '1);
        for (int s = 0; s < 4; s++) begin
            queue_lookup(stim_ids[s]);
        end
        queue_lookup(-32'sd2);
        queue_lookup(32'sd1);
        queue_lookup(32'sh80000001);
        queue_lookup(32'sh7FFFFFFE);
        settle();

        // Full table, then the same table with a count beyond its depth.
        set_layout(TABLE_DEPTH, pick_word(), pick_word(), pick_word());
        fill_table(TABLE_DEPTH, ORDER_STRICT);
        queue_lookups(60, TABLE_DEPTH);
        settle();
        set_layout('1, pick_word(), pick_word(), pick_word());
        queue_lookups(60, TABLE_DEPTH);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       n_slots = 1;
                1:       n_slots = 2;
                2:       n_slots = 0;
                default: n_slots = $urandom_range(3, 40);
            endcase
            case (p % 4)
                1:       order = ORDER_REPEATS;
                3:       order = ORDER_SCRAMBLED;
                default: order = ORDER_STRICT;
            endcase
            set_layout(n_slots, pick_word(), pick_word(), pick_word());
            fill_table(n_slots, order);
            queue_lookups(35, n_slots);
            settle();
        end

        $display("Ran %0d loads and %0d lookups (%0d hits) across %0d table layouts.",
                 loads_taken, lookups_taken, hits_seen, layouts);
        $display("Table sizes ranged from empty to beyond full; %0d mismatches.", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
